// ===== rtl/string_to_unsigned_parser_core_defines.svh =====
// Assertion macros for the string to unsigned parser checker.
`ifndef STRING_TO_UNSIGNED_PARSER_CORE_DEFINES_SVH
`define STRING_TO_UNSIGNED_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define S2U_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("s2u check failed: lbl");

// Next-cycle implication, quiet during reset.
`define S2U_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("s2u check failed: lbl");

// Next-cycle implication that also holds across reset.
`define S2U_ASSERT_ALWAYS_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("s2u check failed: lbl");

`endif

// ===== rtl/s2u_pkg.sv =====
// Types, constants and digit decode for the string to unsigned parser.
package s2u_pkg;

    // Longest string whose length is still counted exactly.
    localparam longint unsigned MAX_CHARS = 64'd65535;
    localparam logic [15:0] COUNT_CAP =
        16'((MAX_CHARS < 64'd65535) ? MAX_CHARS : 64'd65535);

    // Character codes.
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_F_UP   = 8'h46;

    // Radix values.
    localparam logic [4:0] BASE_DEC  = 5'd10;
    localparam logic [4:0] BASE_HEX  = 5'd16;
    localparam logic [4:0] BASE_OCT  = 5'd8;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [63:0] parsed_value;
        logic [15:0] consumed_count;
        logic [4:0]  base_used;
    } t_out_item;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_digit;

    // Decode one character as a hex digit.
    function automatic t_digit digit_decode(input logic [7:0] c);
        t_digit d;
        d.is_hex = 1'b1;
        d.value  = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.value = 4'(c - CH_ZERO);
        end else if (c >= CH_A_LO && c <= CH_F_LO) begin
            d.value = 4'(c - CH_A_LO + 8'd10);
        end else if (c >= CH_A_UP && c <= CH_F_UP) begin
            d.value = 4'(c - CH_A_UP + 8'd10);
        end else begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

    // Count up, holding at the cap.
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v >= COUNT_CAP) ? COUNT_CAP : v + 16'd1;
    endfunction

endpackage

// ===== rtl/string_to_unsigned_parser_core.sv =====
// Top level of the string to unsigned parser: input register, parse step, result register.
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall       | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall     | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_wr_en                   | i_cfg_wr_data (number_base)
//
//  One character per cycle while the input is not stalled; the 64x5 multiply-add of the step unit sets the cycle.
//  A character passes the input register, then the step and the result register.
//  Reset is synchronous and clears the radix register, parse state and valids.
//  Output stall holds only characters that end a string while a result waits.
module string_to_unsigned_parser_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  s2u_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output s2u_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_wr_en,
    input  logic [4:0]          i_cfg_wr_data
);
    import s2u_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic [4:0] r_number_base;
    logic      w_fire;
    logic      w_free;
    logic      w_res_valid;
    t_out_item w_res_item;

    // Radix register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= 5'd0;
        end else if (i_cfg_wr_en) begin
            r_number_base <= i_cfg_wr_data;
        end
    end

    // Process the held item unless it ends a string and the result slot is full.
    assign w_fire     = r_in_valid && (!r_in_item.end_of_string || w_free);
    assign o_in_stall = r_in_valid && !w_fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    s2u_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_item        (r_in_item),
        .i_number_base (r_number_base),
        .o_res_valid   (w_res_valid),
        .o_res_item    (w_res_item)
    );

    s2u_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res_item  (w_res_item),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/s2u_step.sv =====
// Per-character parse step: prefix tracking, radix pick and digit accumulation.
module s2u_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  s2u_pkg::t_in_item   i_item,
    input  logic [4:0]          i_number_base,
    output logic                o_res_valid,
    output s2u_pkg::t_out_item  o_res_item
);
    import s2u_pkg::*;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_ZERO   = 3'd1;
    localparam logic [2:0] PH_ZEROX  = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    logic [63:0] r_acc, n_acc;
    logic [15:0] r_cnt, n_cnt;
    logic [2:0]  r_phase, n_phase;
    logic [4:0]  r_base, n_base;

    t_digit      w_dig;
    logic        w_is_x;
    logic        tk_en;
    logic [4:0]  tk_base;
    logic [63:0] tk_acc;
    logic [15:0] tk_cnt;
    logic        tk_stop;
    logic [63:0] w_prod;
    logic [63:0] w_acc;
    logic [15:0] w_cnt;
    logic [2:0]  w_phase;
    logic [4:0]  w_base;

    // Pick the configured radix unless it is zero.
    function automatic logic [4:0] pick_base(input logic [4:0] nb, input logic [4:0] auto_b);
        return (nb != 5'd0) ? nb : auto_b;
    endfunction

    assign w_dig  = digit_decode(i_item.char_code);
    assign w_is_x = (i_item.char_code == CH_X_LO) || (i_item.char_code == CH_X_UP);

    // Route the phase to the one digit unit.
    always_comb begin
        tk_en   = 1'b0;
        tk_base = r_base;
        tk_acc  = r_acc;
        tk_cnt  = r_cnt;
        w_phase = r_phase;
        w_base  = r_base;
        w_acc   = r_acc;
        w_cnt   = r_cnt;
        unique case (r_phase)
            PH_START: begin
                w_acc = 64'd0;
                w_cnt = 16'd0;
                if (i_item.char_code == CH_ZERO) begin
                    w_phase = PH_ZERO;
                end else begin
                    tk_en   = 1'b1;
                    tk_base = pick_base(i_number_base, BASE_DEC);
                    tk_acc  = 64'd0;
                    tk_cnt  = 16'd0;
                end
            end
            PH_ZERO: begin
                if (w_is_x) begin
                    w_phase = PH_ZEROX;
                end else begin
                    tk_en   = 1'b1;
                    tk_base = pick_base(i_number_base, BASE_OCT);
                    tk_acc  = 64'd0;
                    tk_cnt  = sat_inc(16'd0);
                end
            end
            PH_ZEROX: begin
                if (w_dig.is_hex) begin
                    tk_en   = 1'b1;
                    tk_base = pick_base(i_number_base, BASE_HEX);
                    tk_acc  = 64'd0;
                    tk_cnt  = sat_inc(sat_inc(16'd0));
                end else begin
                    w_base  = pick_base(i_number_base, BASE_OCT);
                    w_acc   = 64'd0;
                    w_cnt   = sat_inc(16'd0);
                    w_phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                tk_en = 1'b1;
            end
            default: begin
                w_phase = PH_DONE;
            end
        endcase

        // Take one digit or stop.
        tk_stop = !w_dig.is_hex || ({1'b0, w_dig.value} >= tk_base);
        w_prod  = tk_acc * 64'(tk_base);
        if (tk_en) begin
            w_base = tk_base;
            w_acc  = tk_acc;
            w_cnt  = tk_cnt;
            if (tk_stop) begin
                w_phase = PH_DONE;
            end else begin
                w_acc   = w_prod + 64'(w_dig.value);
                w_cnt   = sat_inc(tk_cnt);
                w_phase = PH_DIGITS;
            end
        end
    end

    // Close the string on its last character.
    always_comb begin
        o_res_valid = i_fire && i_item.end_of_string;
        o_res_item.parsed_value   = w_acc;
        o_res_item.consumed_count = w_cnt;
        o_res_item.base_used      = w_base;
        if (w_phase == PH_ZERO || w_phase == PH_ZEROX) begin
            o_res_item.parsed_value   = 64'd0;
            o_res_item.consumed_count = sat_inc(16'd0);
            o_res_item.base_used      = pick_base(i_number_base, BASE_OCT);
        end

        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        n_base  = r_base;
        if (i_fire) begin
            if (i_item.end_of_string) begin
                n_acc   = 64'd0;
                n_cnt   = 16'd0;
                n_phase = PH_START;
                n_base  = 5'd0;
            end else begin
                n_acc   = w_acc;
                n_cnt   = w_cnt;
                n_phase = w_phase;
                n_base  = w_base;
            end
        end
    end

    // Hold the parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 64'd0;
            r_cnt   <= 16'd0;
            r_phase <= PH_START;
            r_base  <= 5'd0;
        end else begin
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
            r_base  <= n_base;
        end
    end

endmodule

// ===== rtl/s2u_out_reg.sv =====
// Result register with valid and stall toward the consumer.
module s2u_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  s2u_pkg::t_out_item  i_res_item,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output s2u_pkg::t_out_item  o_out_item
);
    import s2u_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // The slot can take a new result when empty or being drained.
    assign o_free = !r_valid || !i_out_stall;

    // Load a result or drop the one taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_item <= i_res_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

// ===== rtl/s2u_checker.sv =====
// Port-level checks for the string to unsigned parser and their binding.
`include "string_to_unsigned_parser_core_defines.svh"

module s2u_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  s2u_pkg::t_out_item  o_out_item
);
    import s2u_pkg::*;

    // A stalled result stays put.
    `S2U_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // No result right after reset.
    `S2U_ASSERT_ALWAYS_NEXT(a_rst_quiet, !i_rst_n, !o_out_valid)

    // Nothing consumed means nothing accumulated.
    `S2U_ASSERT_NOW(a_empty_zero, o_out_valid && (o_out_item.consumed_count == 16'd0), o_out_item.parsed_value == 64'd0)

    // Every finished string has a radix applied.
    `S2U_ASSERT_NOW(a_base_set, o_out_valid, o_out_item.base_used != 5'd0)

    // A free result side never holds the input.
    `S2U_ASSERT_NOW(a_in_flow, !i_out_stall, !o_in_stall)

endmodule

bind string_to_unsigned_parser_core s2u_checker u_s2u_checker (.*);
